@@ rtl/core/isr_pkg.sv @@
// Shared types, constants and rounding helpers for the isotropic slowness root unit.
// No dependencies; used by isr_recip, isr_sqrt and isotropic_slowness_root_unit.
`default_nettype none

package isr_pkg;

	localparam int unsigned RECIP_STEPS = 64;
	localparam int unsigned SQRT_STEPS  = 32;

	localparam logic [31:0]        RECIP_SEED = 32'h0001_0000;
	localparam logic [31:0]        SMALL_LIM  = 32'h0002_0000;
	localparam logic signed [31:0] DIR_ONE    = 32'sh4000_0000;
	localparam logic signed [31:0] S32_MAX    = 32'sh7fff_ffff;
	localparam logic signed [31:0] S32_MIN    = 32'sh8000_0000;

	localparam logic [4:0] SH_DIR  = 5'd30;
	localparam logic [4:0] SH_VEL  = 5'd28;
	localparam logic [4:0] SH_POL  = 5'd24;

	typedef struct packed {
		logic               refl;
		logic               tiny;
		logic signed [31:0] pl;
		logic signed [31:0] gx;
		logic signed [31:0] gz;
		logic signed [31:0] pm_refl;
		logic [63:0]        plsq;
	} div_tag_t;

	typedef struct packed {
		logic               refl;
		logic               tiny;
		logic               over;
		logic signed [31:0] pl;
		logic signed [31:0] gx;
		logic signed [31:0] gz;
		logic signed [31:0] pm_refl;
		logic [31:0]        a;
	} sqrt_tag_t;

	// round half up, shift right, saturate to signed 32 bits
	function automatic logic signed [31:0] sat_narrow(input logic signed [65:0] v,
		input logic [4:0] sh);
		logic signed [65:0] t;
		t = (v + (66'sd1 <<< (sh - 5'd1))) >>> sh;
		if (t > 66'sd2147483647)
			return S32_MAX;
		else if (t < -66'sd2147483648)
			return S32_MIN;
		else
			return t[31:0];
	endfunction

	function automatic logic signed [31:0] clamp_dir(input logic signed [31:0] v);
		if (v > DIR_ONE)
			return DIR_ONE;
		else if (v < -DIR_ONE)
			return -DIR_ONE;
		else
			return v;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/isr_recip.sv @@
// Pipelined restoring divider: floor(2^80 / a), one quotient bit per stage.
// Depends on isr_pkg for the step count, seed and the side-data type.
`default_nettype none

module isr_recip (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             vld_i,
	input  wire logic [31:0]      a_i,
	input  wire isr_pkg::div_tag_t tag_i,
	output logic                  vld_o,
	output logic [63:0]           quot_o,
	output isr_pkg::div_tag_t     tag_o
);

	localparam int unsigned N = isr_pkg::RECIP_STEPS;

	logic                vld_s  [N];
	logic [31:0]         rem_s  [N];
	logic [63:0]         quot_s [N];
	logic [31:0]         a_s    [N];
	isr_pkg::div_tag_t   tag_s  [N];

	logic                src_vld  [N];
	logic [31:0]         src_rem  [N];
	logic [63:0]         src_quot [N];
	logic [31:0]         src_a    [N];
	isr_pkg::div_tag_t   src_tag  [N];
	logic [31:0]         nxt_rem  [N];
	logic [63:0]         nxt_quot [N];

	always_comb begin
		logic [32:0] r_dbl;
		logic        ge;
		src_vld[0]  = vld_i;
		src_rem[0]  = isr_pkg::RECIP_SEED;
		src_quot[0] = '0;
		src_a[0]    = a_i;
		src_tag[0]  = tag_i;
		for (int k = 1; k < N; k++) begin
			src_vld[k]  = vld_s[k-1];
			src_rem[k]  = rem_s[k-1];
			src_quot[k] = quot_s[k-1];
			src_a[k]    = a_s[k-1];
			src_tag[k]  = tag_s[k-1];
		end
		for (int k = 0; k < N; k++) begin
			r_dbl = {src_rem[k], 1'b0};
			ge    = r_dbl >= {1'b0, src_a[k]};
			nxt_rem[k]  = ge ? 32'(r_dbl - {1'b0, src_a[k]}) : r_dbl[31:0];
			nxt_quot[k] = {src_quot[k][62:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < N; k++) vld_s[k] <= src_vld[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				rem_s[k]  <= nxt_rem[k];
				quot_s[k] <= nxt_quot[k];
				a_s[k]    <= src_a[k];
				tag_s[k]  <= src_tag[k];
			end
		end
	end

	assign vld_o  = vld_s[N-1];
	assign quot_o = quot_s[N-1];
	assign tag_o  = tag_s[N-1];

endmodule

`default_nettype wire

@@ rtl/core/isr_sqrt.sv @@
// Pipelined digit-by-digit floor square root of a 64-bit radicand, one root bit per stage.
// Depends on isr_pkg for the step count and the side-data type.
`default_nettype none

module isr_sqrt (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             vld_i,
	input  wire logic [63:0]      rad_i,
	input  wire isr_pkg::sqrt_tag_t tag_i,
	output logic                  vld_o,
	output logic [31:0]           root_o,
	output isr_pkg::sqrt_tag_t    tag_o
);

	localparam int unsigned N = isr_pkg::SQRT_STEPS;

	logic                vld_s  [N];
	logic [63:0]         x_s    [N];
	logic [33:0]         rem_s  [N];
	logic [31:0]         root_s [N];
	isr_pkg::sqrt_tag_t  tag_s  [N];

	logic                src_vld  [N];
	logic [63:0]         src_x    [N];
	logic [33:0]         src_rem  [N];
	logic [31:0]         src_root [N];
	isr_pkg::sqrt_tag_t  src_tag  [N];
	logic [33:0]         nxt_rem  [N];
	logic [31:0]         nxt_root [N];

	always_comb begin
		logic [35:0] rn;
		logic [35:0] t;
		logic        ge;
		src_vld[0]  = vld_i;
		src_x[0]    = rad_i;
		src_rem[0]  = '0;
		src_root[0] = '0;
		src_tag[0]  = tag_i;
		for (int k = 1; k < N; k++) begin
			src_vld[k]  = vld_s[k-1];
			src_x[k]    = x_s[k-1];
			src_rem[k]  = rem_s[k-1];
			src_root[k] = root_s[k-1];
			src_tag[k]  = tag_s[k-1];
		end
		for (int k = 0; k < N; k++) begin
			rn = {src_rem[k], src_x[k][63:62]};
			t  = {2'b00, src_root[k], 2'b01};
			ge = rn >= t;
			nxt_rem[k]  = ge ? 34'(rn - t) : rn[33:0];
			nxt_root[k] = {src_root[k][30:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < N; k++) vld_s[k] <= src_vld[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				x_s[k]    <= {src_x[k][61:0], 2'b00};
				rem_s[k]  <= nxt_rem[k];
				root_s[k] <= nxt_root[k];
				tag_s[k]  <= src_tag[k];
			end
		end
	end

	assign vld_o  = vld_s[N-1];
	assign root_o = root_s[N-1];
	assign tag_o  = tag_s[N-1];

endmodule

`default_nettype wire

@@ rtl/core/isotropic_slowness_root_unit.sv @@
// Isotropic slowness root unit: normal slowness, group velocity and polarization per ray.
// Pipeline: 3 front stages, 64 divider stages, 1 radicand stage, 32 root stages, 6 back stages.
// Throughput one word per cycle; the whole pipeline holds while a result waits under stall.
// Reset (arst_n, asynchronous) clears all valid bits; data registers are not reset.
// Depends on isr_pkg, isr_recip and isr_sqrt.
`default_nettype none

module isotropic_slowness_root_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic               opcode,
	input  wire logic [31:0]        vel_squared,
	input  wire logic signed [31:0] tang_slowness,
	input  wire logic signed [31:0] dir_cos,
	input  wire logic signed [31:0] dir_sin,
	input  wire logic signed [31:0] in_slow_x,
	input  wire logic signed [31:0] in_slow_z,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic                    status,
	output logic signed [31:0]      out_slow_x,
	output logic signed [31:0]      out_slow_z,
	output logic signed [31:0]      group_vel_x,
	output logic signed [31:0]      group_vel_z,
	output logic signed [31:0]      polar_11,
	output logic signed [31:0]      polar_13,
	output logic signed [31:0]      polar_33
);

	logic en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;

	// s1: register and clamp
	logic               refl_s1;
	logic [31:0]        a_s1;
	logic signed [31:0] pl_s1, gx_s1, gz_s1, px_s1, pz_s1;
	// s2: reflection products and pl^2
	logic               refl_s2;
	logic [31:0]        a_s2;
	logic signed [31:0] pl_s2, gx_s2, gz_s2;
	logic signed [63:0] gzpx_s2, gxpz_s2, plsq_s2;
	// s3
	logic [31:0]        a_s3;
	isr_pkg::div_tag_t  dtag_s3;
	// divider output
	logic               dvld;
	logic [63:0]        dquot;
	isr_pkg::div_tag_t  dtag;
	// s4
	logic [63:0]        rad_s4;
	isr_pkg::sqrt_tag_t stag_s4;
	// root output
	logic               svld;
	logic [31:0]        sroot;
	isr_pkg::sqrt_tag_t stag;
	// s5..s10
	logic               over_s5, over_s6, over_s7, over_s8, over_s9, over_s10;
	logic [31:0]        a_s5, a_s6;
	logic signed [63:0] plgx_s5, pmgz_s5, pmgx_s5, plgz_s5;
	logic signed [31:0] sx_s6, sz_s6, sx_s7, sz_s7, sx_s8, sz_s8, sx_s9, sz_s9;
	logic signed [64:0] sxa_s7, sza_s7;
	logic signed [31:0] vx_s8, vz_s8, vx_s9, vz_s9;
	logic signed [63:0] p11_s9, p13_s9, p33_s9;
	logic signed [31:0] sx_s10, sz_s10, vx_s10, vz_s10, g11_s10, g13_s10, g33_s10;

	logic signed [31:0] pm;

	// a runs through its own delay line beside the divider, then rides in the root pipeline side data
	logic [31:0] a_div;
	logic [31:0] a_dly;
	logic [31:0] a_line_q [isr_pkg::RECIP_STEPS];

	assign en        = !(vld_s10 && rsp_stall);
	assign req_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s1  <= req_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= dvld;
			vld_s5  <= svld;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			refl_s1 <= opcode;
			a_s1    <= vel_squared;
			pl_s1   <= tang_slowness;
			gx_s1   <= isr_pkg::clamp_dir(dir_cos);
			gz_s1   <= isr_pkg::clamp_dir(dir_sin);
			px_s1   <= in_slow_x;
			pz_s1   <= in_slow_z;

			refl_s2 <= refl_s1;
			a_s2    <= a_s1;
			pl_s2   <= pl_s1;
			gx_s2   <= gx_s1;
			gz_s2   <= gz_s1;
			gzpx_s2 <= gz_s1 * px_s1;
			gxpz_s2 <= gx_s1 * pz_s1;
			plsq_s2 <= pl_s1 * pl_s1;

			a_s3            <= a_s2;
			dtag_s3.refl    <= refl_s2;
			dtag_s3.tiny    <= a_s2 < isr_pkg::SMALL_LIM;
			dtag_s3.pl      <= pl_s2;
			dtag_s3.gx      <= gx_s2;
			dtag_s3.gz      <= gz_s2;
			dtag_s3.pm_refl <= isr_pkg::sat_narrow(66'(gzpx_s2) - 66'(gxpz_s2), isr_pkg::SH_DIR);
			dtag_s3.plsq    <= 64'(plsq_s2);
		end
	end

	isr_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s3),
		.a_i    (a_s3),
		.tag_i  (dtag_s3),
		.vld_o  (dvld),
		.quot_o (dquot),
		.tag_o  (dtag)
	);

	assign a_div = a_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s4          <= dquot - dtag.plsq;
			stag_s4.refl    <= dtag.refl;
			stag_s4.tiny    <= dtag.tiny;
			stag_s4.over    <= !dtag.refl && !dtag.tiny && (dquot < dtag.plsq);
			stag_s4.pl      <= dtag.pl;
			stag_s4.gx      <= dtag.gx;
			stag_s4.gz      <= dtag.gz;
			stag_s4.pm_refl <= dtag.pm_refl;
			stag_s4.a       <= a_dly;
		end
	end

	// delay a by the divider depth
	always_ff @(posedge clk) begin
		if (en) begin
			a_line_q[0] <= a_div;
			for (int k = 1; k < isr_pkg::RECIP_STEPS; k++) a_line_q[k] <= a_line_q[k-1];
		end
	end
	assign a_dly = a_line_q[isr_pkg::RECIP_STEPS-1];

	isr_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s4),
		.rad_i  (rad_s4),
		.tag_i  (stag_s4),
		.vld_o  (svld),
		.root_o (sroot),
		.tag_o  (stag)
	);

	always_comb begin
		priority if (stag.refl)
			pm = stag.pm_refl;
		else if (stag.tiny || sroot[31])
			pm = isr_pkg::S32_MAX;
		else
			pm = sroot;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			over_s5 <= stag.over;
			a_s5    <= stag.a;
			plgx_s5 <= stag.pl * stag.gx;
			pmgz_s5 <= pm * stag.gz;
			pmgx_s5 <= pm * stag.gx;
			plgz_s5 <= stag.pl * stag.gz;

			over_s6 <= over_s5;
			a_s6    <= a_s5;
			sx_s6   <= isr_pkg::sat_narrow(66'(plgx_s5) - 66'(pmgz_s5), isr_pkg::SH_DIR);
			sz_s6   <= isr_pkg::sat_narrow(66'(pmgx_s5) + 66'(plgz_s5), isr_pkg::SH_DIR);

			over_s7 <= over_s6;
			sx_s7   <= sx_s6;
			sz_s7   <= sz_s6;
			sxa_s7  <= sx_s6 * $signed({1'b0, a_s6});
			sza_s7  <= sz_s6 * $signed({1'b0, a_s6});

			over_s8 <= over_s7;
			sx_s8   <= sx_s7;
			sz_s8   <= sz_s7;
			vx_s8   <= isr_pkg::sat_narrow(66'(sxa_s7), isr_pkg::SH_VEL);
			vz_s8   <= isr_pkg::sat_narrow(66'(sza_s7), isr_pkg::SH_VEL);

			over_s9 <= over_s8;
			sx_s9   <= sx_s8;
			sz_s9   <= sz_s8;
			vx_s9   <= vx_s8;
			vz_s9   <= vz_s8;
			p11_s9  <= vz_s8 * sz_s8;
			p13_s9  <= vx_s8 * sz_s8;
			p33_s9  <= vx_s8 * sx_s8;

			// zero all data outputs on an overcritical ray; valid and status still pass through
			over_s10 <= over_s9;
			sx_s10   <= over_s9 ? '0 : sx_s9;
			sz_s10   <= over_s9 ? '0 : sz_s9;
			vx_s10   <= over_s9 ? '0 : vx_s9;
			vz_s10   <= over_s9 ? '0 : vz_s9;
			g11_s10  <= over_s9 ? '0 : isr_pkg::sat_narrow(66'(p11_s9), isr_pkg::SH_POL);
			g13_s10  <= over_s9 ? '0 : isr_pkg::sat_narrow(-66'(p13_s9), isr_pkg::SH_POL);
			g33_s10  <= over_s9 ? '0 : isr_pkg::sat_narrow(66'(p33_s9), isr_pkg::SH_POL);
		end
	end

	assign rsp_valid   = vld_s10;
	assign status      = over_s10;
	assign out_slow_x  = sx_s10;
	assign out_slow_z  = sz_s10;
	assign group_vel_x = vx_s10;
	assign group_vel_z = vz_s10;
	assign polar_11    = g11_s10;
	assign polar_13    = g13_s10;
	assign polar_33    = g33_s10;

endmodule

`default_nettype wire
